// File: src/ismt_pkg.sv
// Shared types, constants and codes for the interval set merge table.
`default_nettype none
package ismt_pkg;

    localparam int MAX_INTERVALS_DEF = 16;
    localparam int VAL_W             = 64;
    localparam int COUNT_OUT_W       = 5;
    localparam int STATUS_W          = 2;
    localparam int M_DATA_W          = 1 + COUNT_OUT_W + STATUS_W;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

    typedef struct packed {
        logic [VAL_W-1:0] last_val;
        logic [VAL_W-1:0] first_val;
    } ismt_entry_t;

    typedef struct packed {
        logic covers;
        logic ovl;
        logic a_lt_ms;
        logic b_gt_me;
    } ismt_cmp_t;

endpackage
`default_nettype wire

// File: src/ismt_cmp.sv
// Shared compare unit that tests one stored interval against the item window.
`default_nettype none
module ismt_cmp (
    input  ismt_pkg::ismt_entry_t         entry,
    input  logic [ismt_pkg::VAL_W-1:0]    win_start,
    input  logic [ismt_pkg::VAL_W-1:0]    win_end,
    input  logic [ismt_pkg::VAL_W-1:0]    merge_start,
    input  logic [ismt_pkg::VAL_W-1:0]    merge_end,
    output ismt_pkg::ismt_cmp_t           result
);
    import ismt_pkg::*;

    always_comb begin
        result.covers  = (entry.first_val <= win_start) && (entry.last_val >= win_end);
        result.ovl     = (entry.first_val <= win_end) && (entry.last_val >= win_start);
        result.a_lt_ms = entry.first_val < merge_start;
        result.b_gt_me = entry.last_val > merge_end;
    end

endmodule
`default_nettype wire

// File: src/ismt_table.sv
// Two-bank interval memory with one write port and one registered read port.
`default_nettype none
module ismt_table #(
    parameter int IDX_W = 4
) (
    input  logic                   aclk,
    input  logic                   wr_en,
    input  logic [IDX_W:0]         wr_addr,
    input  ismt_pkg::ismt_entry_t  wr_data,
    input  logic [IDX_W:0]         rd_addr,
    output ismt_pkg::ismt_entry_t  rd_data
);
    import ismt_pkg::*;

    localparam int DEPTH = 1 << (IDX_W + 1);

    ismt_entry_t mem [0:DEPTH-1];
    ismt_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: src/interval_set_merge_table.sv
// Top level of the interval set merge table: sequencer, state and stream ports.
// Each input transaction adds a closed interval to a sorted set of disjoint
// intervals or asks whether one stored interval covers it, and produces one
// result transaction. Work runs one stored entry per cycle through a single
// compare unit, save where the second pass writes the new entry and holds
// the current one back. A query makes one pass over the N stored intervals
// and an add two: one pass reads every entry to test cover and overlap, and
// a second pass streams the entries into the other bank of the table while
// dropping merged entries and inserting the new one in start order. An add
// that is already covered or is dropped for a full table ends after the
// first pass. An item with start above end goes straight to its result, as
// does a query on an empty table. The input is not ready while an item is at
// work, and a finished result waits in an output register.
`default_nettype none
module interval_set_merge_table #(
    parameter int MAX_INTERVALS = ismt_pkg::MAX_INTERVALS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // range_start [63:0], range_end [127:64]
    input  logic [2*ismt_pkg::VAL_W-1:0]      s_tdata,
    // cmd [0]
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // covered [0], interval_count [5:1], status [7:6]
    output logic [ismt_pkg::M_DATA_W-1:0]     m_tdata
);
    import ismt_pkg::*;

    localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CW = $clog2(MAX_INTERVALS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_MERGE = 3'd2;
    localparam logic [2:0] S_TAIL  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic                bank_reg, bank_next;
    logic [CW-1:0]       used_reg, used_next;
    logic [IW-1:0]       cur_reg, cur_next;
    logic [CW-1:0]       wr_idx_reg, wr_idx_next;
    logic                cmd_reg, cmd_next;
    logic [VAL_W-1:0]    s_reg, s_next;
    logic [VAL_W-1:0]    e_reg, e_next;
    logic [VAL_W-1:0]    ms_reg, ms_next;
    logic [VAL_W-1:0]    me_reg, me_next;
    logic                cov_reg, cov_next;
    logic                merged_reg, merged_next;
    logic                ins_done_reg, ins_done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                wr_en;
    logic [IW:0]         wr_addr;
    ismt_entry_t         wr_data;
    logic [IW:0]         rd_addr;
    ismt_entry_t         rd_data;
    ismt_cmp_t           cmp;
    logic                last_entry;
    logic                in_accept;
    logic [VAL_W-1:0]    in_start;
    logic [VAL_W-1:0]    in_end;
    ismt_entry_t         new_entry;

    ismt_table #(
        .IDX_W (IW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ismt_cmp u_cmp (
        .entry       (rd_data),
        .win_start   (s_reg),
        .win_end     (e_reg),
        .merge_start (ms_reg),
        .merge_end   (me_reg),
        .result      (cmp)
    );

    assign s_tready   = (state_reg == S_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign in_start   = s_tdata[VAL_W-1:0];
    assign in_end     = s_tdata[2*VAL_W-1:VAL_W];
    assign last_entry = ((CW'(cur_reg) + CW'(1)) == used_reg);
    assign rd_addr    = {bank_reg, cur_next};
    assign new_entry  = '{last_val: me_reg, first_val: ms_reg};

    always_comb begin
        state_next    = state_reg;
        bank_next     = bank_reg;
        used_next     = used_reg;
        cur_next      = cur_reg;
        wr_idx_next   = wr_idx_reg;
        cmd_next      = cmd_reg;
        s_next        = s_reg;
        e_next        = e_reg;
        ms_next       = ms_reg;
        me_next       = me_reg;
        cov_next      = cov_reg;
        merged_next   = merged_reg;
        ins_done_next = ins_done_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        wr_en         = 1'b0;
        wr_addr       = {!bank_reg, wr_idx_reg[IW-1:0]};
        wr_data       = new_entry;

        unique case (state_reg)
            S_IDLE: begin
                cur_next = '0;
                if (in_accept) begin
                    cmd_next    = s_tuser[0];
                    s_next      = in_start;
                    e_next      = in_end;
                    ms_next     = in_start;
                    me_next     = in_end;
                    cov_next    = 1'b0;
                    merged_next = 1'b0;
                    wr_idx_next = '0;
                    status_next = ST_OK;
                    if (in_start > in_end) begin
                        status_next = ST_BAD;
                        state_next  = S_DONE;
                    end else if (used_reg == '0) begin
                        state_next = (s_tuser[0] == CMD_QUERY) ? S_DONE : S_TAIL;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cov_next    = cov_reg | cmp.covers;
                merged_next = merged_reg | cmp.ovl;
                if (cmp.ovl && cmp.a_lt_ms) begin
                    ms_next = rd_data.first_val;
                end
                if (cmp.ovl && cmp.b_gt_me) begin
                    me_next = rd_data.last_val;
                end
                if (last_entry) begin
                    cur_next      = '0;
                    wr_idx_next   = '0;
                    ins_done_next = 1'b0;
                    if (cmd_reg == CMD_QUERY || cov_next) begin
                        state_next = S_DONE;
                    end else if (!merged_next && used_reg == CW'(MAX_INTERVALS)) begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_MERGE;
                    end
                end else begin
                    cur_next = cur_reg + IW'(1);
                end
            end
            S_MERGE: begin
                if (!cmp.ovl && !ins_done_reg && !cmp.a_lt_ms) begin
                    wr_en         = 1'b1;
                    wr_data       = new_entry;
                    wr_idx_next   = wr_idx_reg + CW'(1);
                    ins_done_next = 1'b1;
                end else begin
                    if (!cmp.ovl) begin
                        wr_en       = 1'b1;
                        wr_data     = rd_data;
                        wr_idx_next = wr_idx_reg + CW'(1);
                    end
                    if (last_entry) begin
                        cur_next = '0;
                        if (ins_done_reg) begin
                            used_next  = wr_idx_next;
                            bank_next  = !bank_reg;
                            state_next = S_DONE;
                        end else begin
                            state_next = S_TAIL;
                        end
                    end else begin
                        cur_next = cur_reg + IW'(1);
                    end
                end
            end
            S_TAIL: begin
                wr_en      = 1'b1;
                wr_data    = new_entry;
                used_next  = wr_idx_reg + CW'(1);
                bank_next  = !bank_reg;
                cur_next   = '0;
                state_next = S_DONE;
            end
            S_DONE: begin
                cur_next = '0;
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {status_reg, COUNT_OUT_W'(used_reg),
                                    cov_reg && (cmd_reg == CMD_QUERY)
                                    && (status_reg == ST_OK)};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            bank_reg    <= 1'b0;
            used_reg    <= '0;
            cur_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bank_reg    <= bank_next;
            used_reg    <= used_next;
            cur_reg     <= cur_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wr_idx_reg   <= wr_idx_next;
        cmd_reg      <= cmd_next;
        s_reg        <= s_next;
        e_reg        <= e_next;
        ms_reg       <= ms_next;
        me_reg       <= me_next;
        cov_reg      <= cov_next;
        merged_reg   <= merged_next;
        ins_done_reg <= ins_done_next;
        status_reg   <= status_next;
        m_data_reg   <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire
